@@ design/fbba_pkg.sv @@
// Shared types, constants and codes of the free block bitmap allocator.
package fbba_pkg;

   localparam int NUM_BLOCKS = 1024;
   localparam int IDX_W      = 10;
   localparam int INDEX_SPAN = 1 << IDX_W;

   // only blocks reachable through the 10-bit index are ever touched
   localparam int SCAN_LIMIT = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;
   localparam int SCAN_BYTES = (SCAN_LIMIT + 7) / 8;
   localparam int ROW_W      = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;
   localparam int LAST_BITS  = SCAN_LIMIT % 8;

   localparam logic [7:0] FULL_BYTE = 8'hFF;
   localparam logic [7:0] TOP_BIT   = 8'h80;
   // usable bits of the last byte, first block in the msb
   localparam logic [7:0] LAST_MASK =
      (LAST_BITS == 0) ? FULL_BYTE : 8'(FULL_BYTE << (8 - LAST_BITS));
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCAN_BYTES - 1);
   localparam logic [16:0] NUM_BLOCKS_W = 17'(NUM_BLOCKS);

   typedef enum logic [1:0] {
      K_ALLOC = 2'd0,
      K_FREE  = 2'd1,
      K_MARK  = 2'd2,
      K_FLIP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_EMIT
   } state_type;

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic       found;
      logic [2:0] pos;
      logic [7:0] new_byte;
   } unit_out_type;

endpackage

@@ design/fbba_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module fbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fbba_byte_unit.sv @@
// Byte unit: first free bit search and bit update for one bitmap byte.
module fbba_byte_unit
   import fbba_pkg::*;
(
   input  kind_type     kind,
   input  logic [7:0]   cur_byte,
   input  logic [7:0]   avail,
   input  logic [2:0]   bit_sel,
   output unit_out_type result
);

   logic [7:0] taken;
   logic       found;
   logic [2:0] pos;
   logic [7:0] mask;

   // bits outside the map count as taken
   assign taken = cur_byte | ~avail;

   always_comb begin
      found = 1'b0;
      pos   = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!taken[7-i]) begin
            found = 1'b1;
            pos   = 3'(i);
         end
      end
   end

   assign mask = TOP_BIT >> ((kind == K_ALLOC) ? pos : bit_sel);

   always_comb begin
      result.found = found;
      result.pos   = pos;
      case (kind)
         K_ALLOC: result.new_byte = cur_byte | mask;
         K_FREE:  result.new_byte = cur_byte & ~mask;
         K_MARK:  result.new_byte = cur_byte | mask;
         K_FLIP:  result.new_byte = cur_byte ^ mask;
         default: result.new_byte = cur_byte;
      endcase
   end

endmodule

@@ design/free_block_bitmap_allocator.sv @@
// Top level: first-fit block allocator over a byte-wide usage bitmap.
//
// Request beats (req_*) carry a kind and a block index: allocate, free, mark
// or flip. Each request yields exactly one response beat (rsp_*) with the
// block number and a status (ok, bitmap full, index out of range).
// One request is worked on at a time; req_stall is high from acceptance until
// the response has been loaded into the output register.
// Free, mark and flip of an in-range block take one read and one write of the
// bitmap RAM (states fetch, check, emit); an out-of-range index goes straight
// to emit with no RAM access. Allocate scans the bitmap RAM one byte per cycle
// from byte 0 and stops at the first byte with a free bit, or at the last byte
// when the bitmap is full.
// The scan rate is set by the single RAM read port.
// Reset clears the per-byte valid flags at once, so the whole bitmap reads as
// free with no clearing sweep; the RAM itself is never cleared.
// A stalled response holds in the output register; the next request is still
// accepted and worked, and waits for the register to free up.
module free_block_bitmap_allocator
   import fbba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] result_ff, result_in;
   status_type status_ff, status_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SCAN_BYTES-1:0] row_valid_ff, row_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic out_range;
   logic load_rsp;
   logic ram_we;
   logic [ROW_W-1:0] ram_rd_addr;
   logic [7:0] ram_rd_data;
   logic [7:0] cur_byte;
   logic [7:0] avail;
   unit_out_type unit_out;

   assign req_accept = req_valid && !req_stall;
   assign out_range  = (17'(req_payload.block_index) >= NUM_BLOCKS_W);

   // a row never written reads as all free
   assign cur_byte = row_valid_ff[row_ff] ? ram_rd_data : 8'h00;
   assign avail    = (row_ff == LAST_ROW) ? LAST_MASK : FULL_BYTE;

   fbba_ram #(
      .WIDTH(8),
      .DEPTH(SCAN_BYTES)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(row_ff),
      .wr_data(unit_out.new_byte),
      .rd_en  (1'b1),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   fbba_byte_unit u_unit (
      .kind    (kind_ff),
      .cur_byte(cur_byte),
      .avail   (avail),
      .bit_sel (idx_ff[2:0]),
      .result  (unit_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_payload.kind != K_ALLOC && out_range) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: state_in = S_CHECK;
         S_CHECK: begin
            if (kind_ff != K_ALLOC || unit_out.found || row_ff == LAST_ROW) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (state_ff != S_IDLE);
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      row_in       = row_ff;
      row_valid_in = row_valid_ff;
      ram_we       = 1'b0;
      load_rsp     = 1'b0;
      ram_rd_addr  = row_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in   = req_payload.kind;
               idx_in    = req_payload.block_index;
               result_in = req_payload.block_index;
               status_in = (req_payload.kind != K_ALLOC && out_range) ? ST_RANGE : ST_OK;
               row_in    = (req_payload.kind == K_ALLOC) ?
                           '0 : req_payload.block_index[3 +: ROW_W];
            end
         end
         S_FETCH: ;
         S_CHECK: begin
            if (kind_ff != K_ALLOC || unit_out.found) begin
               ram_we               = 1'b1;
               row_valid_in[row_ff] = 1'b1;
               if (kind_ff == K_ALLOC) begin
                  result_in = IDX_W'({row_ff, unit_out.pos});
               end
            end else if (row_ff == LAST_ROW) begin
               result_in = '0;
               status_in = ST_FULL;
            end else begin
               // prefetch the next byte so the scan runs one byte a cycle
               row_in      = row_ff + ROW_W'(1);
               ram_rd_addr = row_ff + ROW_W'(1);
            end
         end
         S_EMIT: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_index = result_ff;
         rsp_data_in.status       = status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      result_ff   <= result_in;
      status_ff   <= status_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but block not busy");

   a_full_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL |-> rsp_payload.result_index == '0)
      else $error("full status with nonzero index");

   a_alloc_sets_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK && kind_ff == K_ALLOC && unit_out.found
      |-> unit_out.new_byte != cur_byte)
      else $error("allocate did not take a free bit");

   a_written_row_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> row_valid_ff[$past(row_ff)])
      else $error("written row not marked valid");

endmodule

@@ bench/tb_free_block_bitmap_allocator.sv @@
// Self-checking testbench of the first-fit bitmap block allocator: directed table, then random beats.
module tb_free_block_bitmap_allocator
   import fbba_pkg::*;
();

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] idx;
      bit               typed;
      logic [IDX_W-1:0] want_idx;
      status_type       want_st;
   } row_type;

   // typed rows carry the expected response written in the table; the rest use the predictor
   localparam row_type DIRECTED [25] = '{
      '{K_ALLOC, 10'd0,    1'b1, 10'd0,    ST_OK},
      '{K_ALLOC, 10'd1023, 1'b1, 10'd1,    ST_OK},
      '{K_MARK,  10'd1023, 1'b1, 10'd1023, ST_OK},
      '{K_FLIP,  10'd0,    1'b1, 10'd0,    ST_OK},
      '{K_ALLOC, 10'd512,  1'b1, 10'd0,    ST_OK},
      '{K_FREE,  10'd1,    1'b1, 10'd1,    ST_OK},
      '{K_ALLOC, 10'd0,    1'b1, 10'd1,    ST_OK},
      '{K_FLIP,  10'd2,    1'b1, 10'd2,    ST_OK},
      '{K_ALLOC, 10'd0,    1'b1, 10'd3,    ST_OK},
      '{K_MARK,  10'd4,    1'b1, 10'd4,    ST_OK},
      '{K_MARK,  10'd5,    1'b1, 10'd5,    ST_OK},
      '{K_MARK,  10'd6,    1'b1, 10'd6,    ST_OK},
      '{K_MARK,  10'd7,    1'b1, 10'd7,    ST_OK},
      '{K_ALLOC, 10'd0,    1'b1, 10'd8,    ST_OK},
      '{K_FREE,  10'd1023, 1'b1, 10'd1023, ST_OK},
      '{K_FLIP,  10'd1023, 1'b1, 10'd1023, ST_OK},
      '{K_FLIP,  10'd1023, 1'b1, 10'd1023, ST_OK},
      '{K_FREE,  10'd700,  1'b1, 10'd700,  ST_OK},
      '{K_MARK,  10'd700,  1'b1, 10'd700,  ST_OK},
      '{K_FREE,  10'd0,    1'b1, 10'd0,    ST_OK},
      '{K_ALLOC, 10'd341,  1'b1, 10'd0,    ST_OK},
      '{K_ALLOC, 10'd682,  1'b0, 10'd0,    ST_OK},
      '{K_FLIP,  10'd9,    1'b0, 10'd0,    ST_OK},
      '{K_ALLOC, 10'd1023, 1'b0, 10'd0,    ST_OK},
      '{K_FREE,  10'd700,  1'b0, 10'd0,    ST_OK}
   };

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   bit      block_taken [NUM_BLOCKS];
   rsp_type pending_rsp [$];
   int      errors        = 0;
   bit      quiet         = 1'b0;
   bit      long_hold_req = 1'b0;

   free_block_bitmap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // apply one request to the shadow bitmap and return the response it should get
   function automatic rsp_type apply_request(input req_type r);
      rsp_type o;
      bit      found;
      o.result_index = r.block_index;
      o.status       = ST_OK;
      found          = 1'b0;
      if (r.kind == K_ALLOC) begin
         o.result_index = '0;
         o.status       = ST_FULL;
         for (int b = 0; b < SCAN_LIMIT; b++) begin
            if (!found && !block_taken[b]) begin
               found          = 1'b1;
               block_taken[b] = 1'b1;
               o.result_index = IDX_W'(b);
               o.status       = ST_OK;
            end
         end
      end else if (int'(r.block_index) >= NUM_BLOCKS) begin
         o.status = ST_RANGE;
      end else begin
         case (r.kind)
            K_FREE:  block_taken[r.block_index] = 1'b0;
            K_MARK:  block_taken[r.block_index] = 1'b1;
            default: block_taken[r.block_index] = ~block_taken[r.block_index];
         endcase
      end
      return o;
   endfunction

   task automatic send_req(input kind_type k, input logic [IDX_W-1:0] idx, input bit typed,
                           input rsp_type want);
      req_type r;
      rsp_type p;
      r.kind        = k;
      r.block_index = idx;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      p = apply_request(r);
      pending_rsp.push_back(typed ? want : p);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // random kind, index biased toward the low blocks where allocations pile up
   task automatic send_mixed();
      int       pick;
      kind_type k;
      pick = $urandom_range(0, 19);
      if (pick < 7)       k = K_ALLOC;
      else if (pick < 12) k = K_FREE;
      else if (pick < 15) k = K_MARK;
      else                k = K_FLIP;
      if ($urandom_range(0, 1))
         send_req(k, IDX_W'($urandom_range(0, 95)), 1'b0, '0);
      else
         send_req(k, IDX_W'($urandom_range(0, INDEX_SPAN - 1)), 1'b0, '0);
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      rsp_type want;
      rsp_type got;
      int      hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response beat idx=%0d status=%0d",
                        $time, got.result_index, got.status);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.result_index !== want.result_index) begin
                  $display("%0t: result_index expected %0d got %0d",
                           $time, want.result_index, got.result_index);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, got.status);
                  errors++;
               end
            end
         end
         if (hold_left == 0) begin
            if (long_hold_req) begin
               hold_left     = 300;
               long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               hold_left = $urandom_range(1, 11);
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      rsp_type          want;
      int               free_cnt;
      logic [IDX_W-1:0] blk;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         want.result_index = DIRECTED[i].want_idx;
         want.status       = DIRECTED[i].want_st;
         send_req(DIRECTED[i].kind, DIRECTED[i].idx, DIRECTED[i].typed, want);
      end
      req_valid <= 1'b0;
      drain();

      // receiver holds off while requests keep coming, so the block backs up
      long_hold_req = 1'b1;
      repeat (250) send_mixed();

      // fill every block by allocation, then run into the full bitmap
      free_cnt = 0;
      for (int b = 0; b < SCAN_LIMIT; b++)
         if (!block_taken[b]) free_cnt++;
      repeat (free_cnt + 3) send_req(K_ALLOC, IDX_W'($urandom_range(0, INDEX_SPAN - 1)), 1'b0, '0);

      // punch one hole in the full map, reclaim it, hit full again
      repeat (20) begin
         blk = IDX_W'($urandom_range(0, SCAN_LIMIT - 1));
         send_req($urandom_range(0, 1) ? K_FREE : K_FLIP, blk, 1'b0, '0);
         send_req(K_ALLOC, IDX_W'($urandom_range(0, INDEX_SPAN - 1)), 1'b0, '0);
         send_req(K_ALLOC, IDX_W'($urandom_range(0, INDEX_SPAN - 1)), 1'b0, '0);
      end

      // tail runs back to back on both sides
      quiet = 1'b1;
      repeat (200) send_mixed();
      req_valid <= 1'b0;
      drain();
      repeat (2 * SCAN_BYTES + 10) @(posedge clock);

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
